[rtl/arm_thumb_relocation_patcher_defines.svh]
// Assertion macros for the relocation patcher
`ifndef ARM_THUMB_RELOCATION_PATCHER_DEFINES_SVH
`define ARM_THUMB_RELOCATION_PATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define ATRP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ATRP_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ATRP_ASSERT(label, clk, rstn, prop)
`define ATRP_ASSERT_RST(label, clk, prop)
`endif
`endif

[rtl/atrp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_pkg
// Types and codes of the relocation patcher.
// ----------------------------------------------------------------------------
package atrp_pkg;

    typedef enum logic [4:0] {
        R_NONE = 5'd0, R_PC24 = 5'd1, R_CALL = 5'd2, R_JUMP24 = 5'd3, R_PLT32 = 5'd4,
        R_THM_JUMP6 = 5'd5, R_THM_ALU = 5'd6, R_THM_PC12 = 5'd7, R_THM_PC8 = 5'd8,
        R_THM_JUMP19 = 5'd9, R_THM_PC22 = 5'd10, R_THM_JUMP24 = 5'd11,
        R_MOVT_ABS = 5'd12, R_MOVW_ABS = 5'd13, R_MOVT_PREL = 5'd14,
        R_MOVW_PREL = 5'd15, R_THM_MOVT = 5'd16, R_THM_MOVW = 5'd17,
        R_PREL31 = 5'd18, R_ABS32 = 5'd19, R_REL32 = 5'd20, R_GOTPC = 5'd21,
        R_GOTOFF = 5'd22, R_RODATA = 5'd23, R_GOT32 = 5'd24, R_GOT_SBREL12 = 5'd25,
        R_GOT_PREL = 5'd26, R_V4BX = 5'd27
    } reloc_t;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0, ERR_RANGE = 2'd1, ERR_SLOT = 2'd2
    } err_t;

    localparam logic [2:0] REG_BLX = 3'd0;
    localparam logic [2:0] REG_GOT = 3'd1;
    localparam logic [2:0] REG_RODATA = 3'd2;
    localparam logic [2:0] REG_PLT_START = 3'd3;
    localparam logic [2:0] REG_PLT_LEN = 3'd4;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [31:0] insn_word;
        logic [31:0] place_addr;
        logic [31:0] sym_value;
        logic        weak_undef;
        logic [31:0] got_slot_offset;
    } item_t;

    typedef struct packed {
        logic        blx_available;
        logic [31:0] got_base;
        logic [31:0] rodata_base;
        logic [31:0] plt_start;
        logic [31:0] plt_length;
    } cfg_t;

    typedef struct packed {
        logic [31:0] new_word;
        logic [1:0]  error_code;
    } res_t;

endpackage

[rtl/atrp_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_cfg_regs
// APB register file for the relocation patcher settings.
// ----------------------------------------------------------------------------
module atrp_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output atrp_pkg::cfg_t      cfg
);
    import atrp_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{blx_available: 1'b1, default: '0};
        end else if (wr) begin
            case (idx)
                REG_BLX:       cfg_reg.blx_available <= pwdata[0];
                REG_GOT:       cfg_reg.got_base      <= pwdata;
                REG_RODATA:    cfg_reg.rodata_base   <= pwdata;
                REG_PLT_START: cfg_reg.plt_start     <= pwdata;
                REG_PLT_LEN:   cfg_reg.plt_length    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BLX:       prdata = {31'd0, cfg_reg.blx_available};
            REG_GOT:       prdata = cfg_reg.got_base;
            REG_RODATA:    prdata = cfg_reg.rodata_base;
            REG_PLT_START: prdata = cfg_reg.plt_start;
            REG_PLT_LEN:   prdata = cfg_reg.plt_length;
            default:       prdata = '0;
        endcase
    end
endmodule

[rtl/atrp_patch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_patch
// Combinational patch of one relocation word.
// ----------------------------------------------------------------------------
module atrp_patch (
    input  atrp_pkg::item_t in,
    input  atrp_pkg::cfg_t  cfg,
    output atrp_pkg::res_t  res
);
    import atrp_pkg::*;

    logic [31:0] w, addr, val, slot, r, x, off, xa, xt, xj, xm, xp, xs, a4;
    logic [15:0] hi, lo, h2, l2;
    logic [1:0]  err;
    logic [4:0]  op;
    logic        is_call, th_ko, to_thumb, to_plt, s, i1, i2, tcall;

    always_comb begin
        w = in.insn_word; addr = in.place_addr; val = in.sym_value;
        slot = in.got_slot_offset;
        hi = w[15:0]; lo = w[31:16];
        op = in.opcode;
        // weak undefined targets of kinds R_THM_JUMP6 to R_THM_JUMP24 keep the word
        if (in.weak_undef && op >= R_THM_JUMP6 && op <= R_THM_JUMP24) op = R_NONE;
        err = ERR_OK; r = w;
        x = '0; off = '0; xa = '0; xt = '0; xj = '0; xm = '0; xp = '0; xs = '0;
        a4 = '0; h2 = hi; l2 = lo; is_call = 1'b0; th_ko = 1'b0;
        to_thumb = val[0]; to_plt = 1'b0; s = 1'b0; i1 = 1'b0; i2 = 1'b0;
        tcall = 1'b0;
        case (op)
            R_PC24, R_CALL, R_JUMP24, R_PLT32: begin
                off = {{8{w[23]}}, w[23:0]};
                is_call = (op == R_CALL) || (op == R_PC24 && w[31:24] == 8'heb);
                xa = (off << 2) + val - addr;
                th_ko = (xa[1:0] != 2'd0) && (!cfg.blx_available || !is_call);
                if (th_ko || ((xa + 32'h2000000) >= 32'h4000000)) err = ERR_RANGE;
                if (val[0]) r = {7'b1111101, xa[1], xa[25:2]};
                else        r = {w[31:24], xa[25:2]};
            end
            R_THM_JUMP6: begin
                x = val - addr - 32'd4;
                if (x[31]) r = {w[31:16], 16'hbf00};
                else       r = w | {22'd0, x[6], 1'b0, x[5:1], 3'd0};
            end
            R_THM_ALU: begin
                x = val - {addr[31:2], 2'b00} - 32'd4;
                s = x[31];
                if (s) x = -x;
                h2 = (hi & 16'hfb0f) | {5'd0, x[11], 2'd0, s, 1'b0, s, 5'd0};
                l2 = (lo & 16'h8f00) | {1'b0, x[10:8], 4'd0, x[7:0]};
                r = {l2, h2};
            end
            R_THM_PC12, R_THM_PC8: begin
                a4 = {addr[31:2], 2'b00};
                if (val > a4) x = val - a4 - 32'd4;
                else begin
                    h2 = hi & 16'hff7f;
                    x = a4 + 32'd4 - val;
                end
                if (op == R_THM_PC8) l2 = lo | {8'd0, x[9:2]};
                else                 l2 = lo | {4'd0, x[11:0]};
                r = {l2, h2};
            end
            R_THM_JUMP19: begin
                xj = {{11{hi[10]}}, hi[10], lo[11], lo[13], hi[5:0], lo[10:0], 1'b0};
                xj = xj + val - addr;
                if ((xj + 32'h100000) >= 32'h200000) err = ERR_RANGE;
                h2 = (hi & 16'hfbc0) | {5'd0, xj[20], 4'd0, xj[17:12]};
                l2 = (lo & 16'hd000) | {2'd0, xj[18], 1'b0, xj[19], xj[11:1]};
                r = {l2, h2};
            end
            R_THM_PC22, R_THM_JUMP24: begin
                tcall = (op == R_THM_PC22);
                s = hi[10]; i1 = ~(lo[13] ^ s); i2 = ~(lo[11] ^ s);
                xt = {{7{s}}, s, i1, i2, hi[9:0], lo[10:0], 1'b0};
                xt = xt + val - addr;
                to_plt = (cfg.plt_length != 0) && ((val - cfg.plt_start) < cfg.plt_length);
                if (tcall && !to_thumb) xt = (xt + 32'd3) & ~32'd3;
                if ((!to_thumb || ((xt + 32'h1000000) >= 32'h2000000)) &&
                    (to_thumb || val[1] || (!tcall && !to_plt))) err = ERR_RANGE;
                h2 = (hi & 16'hf800) | {5'd0, xt[24], xt[21:12]};
                l2 = (lo & 16'hc000) | {2'd0, ~(xt[23] ^ xt[24]),
                     !(tcall && !to_thumb), ~(xt[22] ^ xt[24]), xt[11:1]};
                r = {l2, h2};
            end
            R_MOVT_ABS, R_MOVW_ABS: begin
                x = (op == R_MOVT_ABS) ? {16'd0, val[31:16]} : val;
                r = w + {12'd0, x[15:12], 4'd0, x[11:0]};
            end
            R_MOVT_PREL, R_MOVW_PREL: begin
                xm = {{16{w[19]}}, w[19:16], w[11:0]};
                xm = val + xm - addr;
                if (op == R_MOVT_PREL) xm = {16'd0, xm[31:16]};
                r = {w[31:20], xm[15:12], w[15:12], xm[11:0]};
            end
            R_THM_MOVT, R_THM_MOVW: begin
                x = (op == R_THM_MOVT) ? {16'd0, val[31:16]} : val;
                x = {1'b0, x[10:8], 4'd0, x[7:0], 5'd0, x[11], 6'd0, x[15:12]};
                r = (op == R_THM_MOVT) ? (w | x) : (w + x);
            end
            R_PREL31: begin
                xp = {w[30], w[30:0]} + val - addr;
                if (xp[30] ^ xp[31]) err = ERR_RANGE;
                r = {w[31], xp[30:0]};
            end
            R_ABS32:  r = w + val;
            R_REL32:  r = w + val - addr;
            R_GOTPC:  r = w + cfg.got_base - addr;
            R_GOTOFF: r = w + val - cfg.got_base;
            R_RODATA: r = w + val - cfg.rodata_base;
            R_GOT32:  r = slot;
            R_GOT_SBREL12: begin
                if (slot > 32'hfff) err = ERR_SLOT;
                else r = {w[31:28], slot[11:0], w[15:0]};
            end
            R_GOT_PREL: begin
                xs = cfg.got_base + slot;
                r = xs - addr - 32'd8;
            end
            R_V4BX: begin
                if ((w & 32'h0ffffff0) == 32'h012fff10)
                    r = w ^ (32'he12fff10 ^ 32'he1a0f000);
            end
            default: ;
        endcase
        res.new_word = r;
        res.error_code = err;
    end
endmodule

[rtl/arm_thumb_relocation_patcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_thumb_relocation_patcher
// Applies one ARM/Thumb relocation per transaction.
// ----------------------------------------------------------------------------
// Input stream s_axis: one relocation per transaction, kind on tuser.
// Output stream m_axis: patched word and error code.
// Settings registers on the APB port (byte address 4*i) are to be written only
// while idle, by the user; the block itself does not enforce this.
// Each transaction is captured in an input register, patched by one level
// of logic and held in a result register; one per cycle unless stalled.
// The input register takes a new transaction whenever it is empty or its
// contents move into the result register. A stalled receiver holds the
// result register; once both registers are full, s_axis_tready follows
// m_axis_tready in the same cycle.
// Synchronous reset empties both registers and restores the settings:
// blx_available to 1 and all addresses and lengths to 0.
// ----------------------------------------------------------------------------
`include "arm_thumb_relocation_patcher_defines.svh"
module arm_thumb_relocation_patcher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // insn_word[31:0], place_addr[63:32], sym_value[95:64], weak_undef[96],
    // got_slot_offset[128:97], zero fill [135:129]
    input  logic [135:0] s_axis_tdata,
    // opcode[4:0]
    input  logic [4:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_word[31:0], error_code[33:32], zero fill [39:34]
    output logic [39:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import atrp_pkg::*;

    cfg_t  cfg;
    item_t in_reg;
    res_t  res_next, res_reg;
    logic  in_valid_reg, out_valid_reg, adv;

    atrp_cfg_regs u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .cfg
    );

    atrp_patch u_patch (.in(in_reg), .cfg, .res(res_next));

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, res_reg.error_code, res_reg.new_word};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_axis_tready) in_valid_reg <= s_axis_tvalid;
            if (adv) out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_reg <= '{opcode: s_axis_tuser, insn_word: s_axis_tdata[31:0],
                        place_addr: s_axis_tdata[63:32], sym_value: s_axis_tdata[95:64],
                        weak_undef: s_axis_tdata[96],
                        got_slot_offset: s_axis_tdata[128:97]};
        end
        if (adv && in_valid_reg) res_reg <= res_next;
    end

    `ATRP_ASSERT(a_err_code, aclk, aresetn, m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    `ATRP_ASSERT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `ATRP_ASSERT(a_fwd, aclk, aresetn, in_valid_reg && adv |=> out_valid_reg)
    `ATRP_ASSERT_RST(a_reset, aclk, !aresetn |=> !m_axis_tvalid)
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the relocation patcher against an in-bench patch predictor, using
// directed relocations of every kind, randomised streams and register settings.
// ----------------------------------------------------------------------------
module testbench;
    import atrp_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic [4:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    arm_thumb_relocation_patcher i_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    cfg_t        cfg;
    res_t        patch_q[$];
    int unsigned n_fail = 0;
    int unsigned n_cycle = 0;
    bit          calm = 1'b0;

    // ---------------------------------------------------------------- predictor
    function automatic logic [31:0] join16(logic [31:0] lo, logic [31:0] hi);
        return {hi[15:0], lo[15:0]};
    endfunction

    function automatic logic [31:0] pred_a32(reloc_t op, logic [31:0] w, logic [31:0] a,
                                             logic [31:0] v, inout logic [1:0] e);
        logic [31:0] off, x;
        logic        is_call;
        off = {{8{w[23]}}, w[23:0]};
        is_call = (op == R_CALL) || (op == R_PC24 && w[31:24] == 8'heb);
        x = (off << 2) + v - a;
        if ((x[1:0] != 0 && (!cfg.blx_available || !is_call)) ||
            (x + 32'h2000000) >= 32'h4000000)
            e = ERR_RANGE;
        if (v[0]) return {7'b1111101, x[1], x[25:2]};
        return {w[31:24], x[25:2]};
    endfunction

    function automatic logic [31:0] pred_thm_br(bit is_call, logic [31:0] w, logic [31:0] a,
                                                logic [31:0] v, inout logic [1:0] e);
        logic [31:0] hi, lo, x, bb;
        logic        s, j1, j2, to_t, to_plt, out;
        hi = w[15:0]; lo = w[31:16];
        s = hi[10]; j1 = lo[13]; j2 = lo[11];
        x = {7'd0, s, ~(j1 ^ s), ~(j2 ^ s), hi[9:0], lo[10:0], 1'b0};
        to_t = v[0];
        to_plt = cfg.plt_length != 0 && (v - cfg.plt_start) < cfg.plt_length;
        bb = 32'h1000;
        x = (x ^ 32'h1000000) - 32'h1000000;
        x = x + v - a;
        if (is_call && !to_t) begin
            bb = 0;
            x = (x + 3) & ~32'd3;
        end
        out = (x + 32'h1000000) >= 32'h2000000;
        if ((!to_t || out) && (to_t || v[1] || (!is_call && !to_plt))) e = ERR_RANGE;
        j1 = x[24] ^ ~x[23];
        j2 = x[24] ^ ~x[22];
        hi = (hi & 32'hf800) | (x[24] << 10) | x[21:12];
        lo = (lo & 32'hc000) | (j1 << 13) | bb | (j2 << 11) | x[11:1];
        return join16(hi, lo);
    endfunction

    function automatic logic [31:0] pred_pcrel(logic [31:0] w, logic [31:0] ad,
                                               logic [31:0] v, bit words);
        logic [31:0] hi, lo, a, x;
        hi = w[15:0]; lo = w[31:16];
        a = ad & ~32'd3;
        if (v > a) x = v - a - 4;
        else begin
            hi = hi & 32'hff7f;
            x = a + 4 - v;
        end
        if (words) lo = lo | x[9:2];
        else lo = lo | x[11:0];
        return join16(hi, lo);
    endfunction

    function automatic res_t patch_word(item_t it);
        reloc_t      op;
        logic [31:0] w, a, v, sl, r, x, hi, lo;
        logic [1:0]  e;
        op = reloc_t'(it.opcode);
        w = it.insn_word; a = it.place_addr; v = it.sym_value; sl = it.got_slot_offset;
        e = ERR_OK; r = w;
        if (it.weak_undef && it.opcode >= R_THM_JUMP6 && it.opcode <= R_THM_JUMP24) op = R_NONE;
        case (op)
            R_PC24, R_CALL, R_JUMP24, R_PLT32: r = pred_a32(op, w, a, v, e);
            R_THM_JUMP6: begin
                x = v - a - 4;
                if (x[31]) r = {w[31:16], 16'hbf00};
                else begin
                    x = x >> 1;
                    r = w | (x[5] << 9) | (x[4:0] << 3);
                end
            end
            R_THM_ALU: begin
                x = v - (a & ~32'd3) - 4;
                hi = w[15:0] & 32'hfb0f; lo = w[31:16] & 32'h8f00;
                if (x[31]) begin
                    hi = hi | 32'ha0;
                    x = -x;
                end
                r = join16(hi | (x[11] << 10), lo | (x[10:8] << 12) | x[7:0]);
            end
            R_THM_PC12: r = pred_pcrel(w, a, v, 1'b0);
            R_THM_PC8: r = pred_pcrel(w, a, v, 1'b1);
            R_THM_JUMP19: begin
                hi = w[15:0]; lo = w[31:16];
                x = {11'd0, hi[10], lo[11], lo[13], hi[5:0], lo[10:0], 1'b0};
                x = (x ^ 32'h100000) - 32'h100000;
                x = x + v - a;
                if ((x + 32'h100000) >= 32'h200000) e = ERR_RANGE;
                hi = (hi & 32'hfbc0) | (x[20] << 10) | x[17:12];
                lo = (lo & 32'hd000) | (x[18] << 13) | (x[19] << 11) | x[11:1];
                r = join16(hi, lo);
            end
            R_THM_PC22: r = pred_thm_br(1'b1, w, a, v, e);
            R_THM_JUMP24: r = pred_thm_br(1'b0, w, a, v, e);
            R_MOVT_ABS, R_MOVW_ABS: begin
                x = (op == R_MOVT_ABS) ? (v >> 16) : v;
                r = w + {12'd0, x[15:12], 4'd0, x[11:0]};
            end
            R_MOVT_PREL, R_MOVW_PREL: begin
                x = {{16{w[19]}}, w[19:16], w[11:0]};
                x = v + x - a;
                if (op == R_MOVT_PREL) x = x >> 16;
                r = (w & 32'hfff0f000) | (x[15:12] << 16) | x[11:0];
            end
            R_THM_MOVT, R_THM_MOVW: begin
                x = (op == R_THM_MOVT) ? (v >> 16) : v;
                x = {1'b0, x[10:8], 4'd0, x[7:0], 5'd0, x[11], 6'd0, x[15:12]};
                r = (op == R_THM_MOVT) ? (w | x) : (w + x);
            end
            R_PREL31: begin
                x = {w[30], w[30:0]};
                x = x + v - a;
                if (x[30] ^ x[31]) e = ERR_RANGE;
                r = {w[31], x[30:0]};
            end
            R_ABS32: r = w + v;
            R_REL32: r = w + v - a;
            R_GOTPC: r = w + cfg.got_base - a;
            R_GOTOFF: r = w + v - cfg.got_base;
            R_RODATA: r = w + v - cfg.rodata_base;
            R_GOT32: r = sl;
            R_GOT_SBREL12: begin
                if (sl > 32'hfff) e = ERR_SLOT;
                else r = {w[31:28], sl[11:0], w[15:0]};
            end
            R_GOT_PREL: r = cfg.got_base + sl - a - 8;
            R_V4BX: if ((w & 32'h0ffffff0) == 32'h012fff10) r = w ^ (32'he12fff10 ^ 32'he1a0f000);
            default: ;
        endcase
        return '{new_word: r, error_code: e};
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic send_reloc(item_t it);
        while (!calm && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.opcode;
        s_axis_tdata  <= {7'd0, it.got_slot_offset, it.weak_undef, it.sym_value,
                          it.place_addr, it.insn_word};
        patch_q.push_back(patch_word(it));
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (patch_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_BLX: cfg.blx_available = val[0];
            REG_GOT: cfg.got_base = val;
            REG_RODATA: cfg.rodata_base = val;
            REG_PLT_START: cfg.plt_start = val;
            default: cfg.plt_length = val;
        endcase
    endtask

    // receiver and checker
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{new_word: m_axis_tdata[31:0], error_code: m_axis_tdata[33:32]};
            if (patch_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_fail++;
            end else begin
                want = patch_q.pop_front();
                if (got.new_word !== want.new_word) begin
                    $display("%0t: new_word expected %h actual %h", $time, want.new_word,
                             got.new_word);
                    n_fail++;
                end
                if (got.error_code !== want.error_code) begin
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             want.error_code, got.error_code);
                    n_fail++;
                end
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge aclk) begin
        n_cycle++;
        if (n_cycle > 200000) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests
    function automatic item_t rand_reloc(int lo_op, int hi_op);
        item_t it;
        it.opcode = 5'($urandom_range(hi_op, lo_op));
        it.insn_word = $urandom;
        it.place_addr = $urandom;
        // keep many targets within branch range of the place
        it.sym_value = ($urandom_range(1)) ? $urandom : it.place_addr + ($urandom_range(8191)
                       - 4096) * (1 << $urandom_range(12));
        it.weak_undef = 1'($urandom_range(1));
        it.got_slot_offset = $urandom_range(1) ? $urandom_range(8191) : $urandom;
        return it;
    endfunction

    task automatic test_directed;
        item_t it;
        for (int k = 0; k < 32; k++) begin
            it = '{opcode: 5'(k), insn_word: 32'hffff_ffff, place_addr: 32'h8000,
                   sym_value: (k & 1) ? 32'h9001 : 32'h7000, weak_undef: 1'b0,
                   got_slot_offset: 32'h1000};
            if (k == 2) it.insn_word = 32'hebff_fffe;
            if (k == 27) it.insn_word = 32'he12f_ff1e;
            if (k == 9) it.weak_undef = 1'b1;
            send_reloc(it);
        end
        send_reloc('{R_GOT_SBREL12, 32'h0, 32'h0, 32'h0, 1'b0, 32'hfff});
        send_reloc('{R_THM_ALU, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0});
        send_reloc('{R_PC24, 32'heb00_0000, 32'h0, 32'hffff_ffff, 1'b0, 32'hffff_ffff});
    endtask

    task automatic test_random(int n, int lo_op, int hi_op);
        for (int k = 0; k < n; k++) send_reloc(rand_reloc(lo_op, hi_op));
    endtask

    task automatic test_settings;
        logic [31:0] v;
        for (int p = 0; p < 4; p++) begin
            drain();
            v = (p == 0) ? 32'hffff_ffff : (p == 1) ? 32'h0 : $urandom;
            write_reg(REG_BLX, 32'(p[0]));
            write_reg(REG_GOT, v);
            write_reg(REG_RODATA, ~v);
            write_reg(REG_PLT_START, $urandom);
            write_reg(REG_PLT_LEN, (p == 1) ? 32'h0 : v);
            test_random(120, 0, 31);
            test_random(60, R_PC24, R_THM_JUMP24);
        end
    endtask

    initial begin
        cfg = '{blx_available: 1'b1, default: '0};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(150, 0, 31);
        calm = 1'b1;
        test_random(100, 0, 31);
        calm = 1'b0;
        test_settings();
        drain();
        if (n_fail == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
